// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/npf_pkg.sv =====
// Shared widths, codes and controller/datapath interface types.
package npf_pkg;

  localparam int IN_W   = 32;
  localparam int CAND_W = 31;
  localparam int DIV_W  = 17;
  localparam int DSQ_W  = 33;
  localparam int CNT_W  = 5;

  localparam logic SEL_D  = 1'b0;
  localparam logic SEL_D2 = 1'b1;

  typedef struct packed {
    logic       load;
    logic       inc;
    logic       init_d;
    logic       step_d;
    logic       mod_start;
    logic       mod_sel;
    logic       out_load;
  } npf_cmd_t;

  typedef struct packed {
    logic le_three;
    logic even;
    logic mult3;
    logic mod_busy;
    logic rem_zero;
    logic dsq_gt;
  } npf_stat_t;

endpackage

// ===== sv/npf_rem_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle.
module npf_rem_unit
  import npf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CAND_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              busy,
  output logic              rem_zero
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(CAND_W - 1);

  logic [CAND_W-1:0] shifter;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  div_hold;
  logic [CNT_W-1:0]  count;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;

  assign trial    = {rem, shifter[CAND_W-1]};
  assign diff     = trial - {1'b0, div_hold};
  assign rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shifter  <= dividend;
      div_hold <= divisor;
      rem      <= '0;
    end else if (busy) begin
      shifter <= {shifter[CAND_W-2:0], 1'b0};
      // subtract when the partial remainder reaches the divisor
      if (trial >= {1'b0, div_hold}) begin
        rem <= diff[DIV_W-1:0];
      end else begin
        rem <= trial[DIV_W-1:0];
      end
    end
  end

endmodule

// ===== sv/npf_datapath.sv =====
// Candidate, trial divisor, divisor square and result registers.
module npf_datapath
  import npf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  npf_cmd_t          cmd,
  input  logic [IN_W-1:0]   start_value,
  output npf_stat_t         stat,
  output logic [CAND_W-1:0] prime_value
);

  logic [CAND_W-1:0] cand;
  logic [DIV_W-1:0]  d;
  logic [DSQ_W-1:0]  dsq;
  logic [DIV_W-1:0]  divisor;
  logic [DSQ_W-1:0]  dsq_step;
  logic              in_small;
  logic              mod_busy;
  logic              rem_zero;

  // 2^8 and 2^4 are both 1 mod 3: fold bytes, then nibbles
  function automatic logic mult_of_three(input logic [CAND_W-1:0] n);
    logic [9:0] byte_sum;
    logic [5:0] nib_sum;
    byte_sum = 10'(n[7:0]) + 10'(n[15:8]) + 10'(n[23:16]) + 10'(n[30:24]);
    nib_sum  = 6'(byte_sum[3:0]) + 6'(byte_sum[7:4]) + 6'(byte_sum[9:8]);
    return nib_sum inside {6'd0, 6'd3, 6'd6, 6'd9, 6'd12, 6'd15,
                           6'd18, 6'd21, 6'd24, 6'd27, 6'd30, 6'd33};
  endfunction

  assign in_small = start_value[IN_W-1] | (start_value[CAND_W-1:0] <= CAND_W'(2));
  // (d+6)^2 - d^2 = 12d + 36
  assign dsq_step = (DSQ_W'(d) << 3) + (DSQ_W'(d) << 2) + DSQ_W'(36);

  assign divisor = (cmd.mod_sel == SEL_D2) ? d + DIV_W'(2) : d;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand <= in_small ? CAND_W'(2) : start_value[CAND_W-1:0];
    end else if (cmd.inc) begin
      cand <= cand + 1'b1;
    end
    if (cmd.init_d) begin
      d   <= DIV_W'(5);
      dsq <= DSQ_W'(25);
    end else if (cmd.step_d) begin
      d   <= d + DIV_W'(6);
      dsq <= dsq + dsq_step;
    end
    if (cmd.out_load) begin
      prime_value <= cand;
    end
  end

  npf_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (cand),
    .divisor  (divisor),
    .busy     (mod_busy),
    .rem_zero (rem_zero)
  );

  assign stat.le_three = (cand <= CAND_W'(3));
  assign stat.even     = ~cand[0];
  assign stat.mult3    = mult_of_three(cand);
  assign stat.mod_busy = mod_busy;
  assign stat.rem_zero = rem_zero;
  assign stat.dsq_gt   = (dsq > DSQ_W'(cand));

endmodule

// ===== sv/npf_ctrl.sv =====
// Search sequencer: small checks, divisor pair loop, result handoff.
module npf_ctrl
  import npf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  npf_stat_t stat,
  output npf_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_PAIR  = 4'd3;
  localparam logic [3:0] S_WAITA = 4'd4;
  localparam logic [3:0] S_WAITB = 4'd5;
  localparam logic [3:0] S_INC   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid & ~out_ready;
    cmd            = '0;
    cmd.mod_sel    = SEL_D;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.le_three) begin
          state_next = S_DONE;
        end else if (stat.even || stat.mult3) begin
          state_next = S_INC;
        end else begin
          cmd.init_d = 1'b1;
          state_next = S_PAIR;
        end
      end
      S_PAIR: begin
        if (stat.dsq_gt) begin
          state_next = S_DONE;
        end else begin
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = SEL_D;
          state_next    = S_WAITA;
        end
      end
      S_WAITA: begin
        if (!stat.mod_busy) begin
          if (stat.rem_zero) begin
            state_next = S_INC;
          end else begin
            cmd.mod_start = 1'b1;
            cmd.mod_sel   = SEL_D2;
            state_next    = S_WAITB;
          end
        end
      end
      S_WAITB: begin
        if (!stat.mod_busy) begin
          if (stat.rem_zero) begin
            state_next = S_INC;
          end else begin
            cmd.step_d = 1'b1;
            state_next = S_PAIR;
          end
        end
      end
      S_INC: begin
        cmd.inc    = 1'b1;
        state_next = S_CHECK;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/next_prime_finder_unit.sv =====
// Next prime finder top level: sequencer plus datapath.
// Returns the smallest prime at or above a signed 32-bit start value (2 for
// any start of 2 or below). One word is searched at a time: each candidate
// gets the 2 and 3 checks and, if it passes them, a trial division by the
// pairs 6k-1 and 6k+1 while (6k-1)^2 <= candidate, on the one-bit-per-cycle
// remainder unit in the datapath. The next start word is taken while the
// previous result still waits in the output register.
module next_prime_finder_unit
  import npf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   start_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CAND_W-1:0] prime_value
);

  npf_cmd_t  cmd;
  npf_stat_t stat;

  npf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  npf_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .start_value (start_value),
    .stat        (stat),
    .prime_value (prime_value)
  );

endmodule

// ===== sv/npf_checker.sv =====
// Port-level checker for the next prime finder, bound to the top level.
`include "assert_macros.svh"

module npf_checker
  import npf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [IN_W-1:0]   start_value,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CAND_W-1:0] prime_value
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(prime_value))
  `ASSERT_IMPLIES(a_min_two, clk, rst, out_valid, prime_value >= CAND_W'(2))
  `ASSERT_IMPLIES(a_odd_or_two, clk, rst, out_valid, prime_value[0] || prime_value == CAND_W'(2))
  `ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind next_prime_finder_unit npf_checker u_npf_checker (.*);
